[rtl/core/smm_pkg.sv]
`default_nettype none

package smm_pkg;

  // Channel and port widths
  localparam int IN_W     = 32;
  localparam int OUT_W    = 176;
  localparam int SMP_W    = 16;
  localparam int GAIN_W   = 8;
  localparam int PROD_W   = SMP_W + GAIN_W + 1;
  localparam int QUO_W    = 16;
  localparam int PERM_W   = 10;
  localparam int TOTAL_W  = 32;
  localparam int CFG_AW   = 4;
  localparam int CFG_DW   = 32;

  // Register reset values and arithmetic constants
  localparam logic [GAIN_W-1:0]       GAIN_RST = 8'd1;
  localparam logic [SMP_W-1:0]        CLIP_RST = 16'd30000;
  localparam logic signed [SMP_W-1:0] SMP_MAX  = 16'sh7FFF;
  localparam logic signed [SMP_W-1:0] SMP_MIN  = 16'sh8000;
  localparam int                      PERMILLE = 1000;

  // Configuration register indexes (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_GAIN = 2'd0,
    REG_CLIP = 2'd1,
    REG_MUTE = 2'd2
  } smm_reg_t;

  // Quotients produced at the end of a frame, in issue order
  typedef enum logic [2:0] {
    DIV_MEAN_L = 3'd0,
    DIV_MEAN_R = 3'd1,
    DIV_EQUAL  = 3'd2,
    DIV_CLIP_L = 3'd3,
    DIV_CLIP_R = 3'd4
  } smm_div_sel_t;

  typedef struct packed {
    logic         take_in;
    logic         mul_left;
    logic         accum;
    logic         div_start;
    logic         div_store;
    smm_div_sel_t div_sel;
    logic         load_out;
  } smm_cmd_t;

  typedef struct packed {
    logic frame_end;
    logic div_done;
    logic out_free;
  } smm_sts_t;

endpackage

`default_nettype wire

[rtl/core/stereo_mic_mix_and_level_meter_unit.sv]
// Stereo microphone mixer with per-frame level meter.
// Input stream: one stereo pair per request, in_tdata = {left, right} (right in the low
// half), in_tlast marks the last pair of a frame. Each channel is scaled by the gain
// register and saturated to 16 bits; every unmuted request yields one result with the mono mix
// (sum halved toward zero). On the last pair of a frame, or on the pair that brings the
// frame to MAX_FRAME pairs, the result also carries the frame statistics and out_tlast.
// Each pair passes accept, left gain multiply, accumulate and output load in turn, the
// single gain multiplier being shared by both channels; no new pair is taken before
// that load. A frame-ending pair also runs five divisions by the frame length one after
// another, before its load, on a shared restoring divider giving one quotient bit per cycle.
// While the mute register is set, requests are taken and dropped with no state change.
// The output register decouples the two sides: a new pair is accepted while a result
// waits; when out_tready stays low, the next result waits in the controller and
// in_tready drops until the output register frees up.
// Reset (synchronous, active low) restores gain 1, clip level 30000, mute off, clears
// all frame accumulators and the running pair total. No clearing pass is needed.
// Configuration: APB-style, registers gain (0x0), clip_level (0x4), muted (0x8);
// write only while the block is idle.
`default_nettype none

module stereo_mic_mix_and_level_meter_unit #(
  parameter int MAX_FRAME = 512
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // in_tdata: right_sample[15:0], left_sample[31:16]
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [smm_pkg::IN_W-1:0]      in_tdata,
  input  wire logic                          in_tlast,
  // out_tdata: mono_out[15:0], mean_l[31:16], mean_r[47:32],
  // peak_l[63:48], peak_r[79:64], span_l[95:80], span_r[111:96],
  // eq_pm[121:112], clip_pm_l[131:122],
  // clip_pm_r[141:132], total_pairs[173:142], zero pad [175:174]
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [smm_pkg::OUT_W-1:0]          out_tdata,
  output logic                               out_tlast,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [smm_pkg::CFG_AW-1:0]    cfg_paddr,
  input  wire logic [smm_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [smm_pkg::CFG_DW-1:0]         cfg_prdata,
  output logic                               cfg_pready
);

  // Configuration registers
  logic [smm_pkg::GAIN_W-1:0] gain_r;
  logic [smm_pkg::SMP_W-1:0]  clip_r;
  logic                       muted_r;
  logic                       cfg_wr;
  smm_pkg::smm_reg_t          cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = smm_pkg::smm_reg_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= smm_pkg::GAIN_RST;
      clip_r  <= smm_pkg::CLIP_RST;
      muted_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        smm_pkg::REG_GAIN: gain_r  <= cfg_pwdata[smm_pkg::GAIN_W-1:0];
        smm_pkg::REG_CLIP: clip_r  <= cfg_pwdata[smm_pkg::SMP_W-1:0];
        smm_pkg::REG_MUTE: muted_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register; unmapped addresses read zero
  always_comb begin
    unique case (cfg_idx)
      smm_pkg::REG_GAIN: cfg_prdata = smm_pkg::CFG_DW'(gain_r);
      smm_pkg::REG_CLIP: cfg_prdata = smm_pkg::CFG_DW'(clip_r);
      smm_pkg::REG_MUTE: cfg_prdata = smm_pkg::CFG_DW'(muted_r);
      default:           cfg_prdata = '0;
    endcase
  end

  // Controller and datapath joined by command and status
  smm_pkg::smm_cmd_t cmd;
  smm_pkg::smm_sts_t sts;

  smm_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid_i (in_tvalid),
    .muted_i     (muted_r),
    .sts_i       (sts),
    .in_tready_o (in_tready),
    .cmd_o       (cmd)
  );

  smm_datapath #(
    .MAX_FRAME (MAX_FRAME)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .gain_i     (gain_r),
    .clip_i     (clip_r),
    .in_data_i  (in_tdata),
    .in_last_i  (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

[rtl/core/smm_div.sv]
`default_nettype none

// Restoring divider, one quotient bit per cycle; quotient must fit QUO_W bits.
module smm_div #(
  parameter int DIVD_W = 26,
  parameter int DSR_W  = 10
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start_i,
  input  wire logic [DIVD_W-1:0]            dividend_i,
  input  wire logic [DSR_W-1:0]             divisor_i,
  output logic                              done_o,
  output logic [smm_pkg::QUO_W-1:0]         quo_o
);

  localparam int STEP_W = $clog2(smm_pkg::QUO_W);

  logic [DIVD_W-1:0]         rem_r, rem_nxt;
  logic [DIVD_W-1:0]         den_r, den_nxt;
  logic [smm_pkg::QUO_W-1:0] quo_r, quo_nxt;
  logic [STEP_W-1:0]         step_r, step_nxt;
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic                      ge;

  assign ge = (rem_r >= den_r);

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start_i) begin
      rem_nxt  = dividend_i;
      den_nxt  = DIVD_W'(divisor_i) << (smm_pkg::QUO_W - 1);
      quo_nxt  = '0;
      step_nxt = STEP_W'(smm_pkg::QUO_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (ge) begin
        rem_nxt = rem_r - den_r;
      end
      quo_nxt = {quo_r[smm_pkg::QUO_W-2:0], ge};
      den_nxt = den_r >> 1;
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign done_o = done_r;
  assign quo_o  = quo_r;

endmodule

`default_nettype wire

[rtl/core/smm_datapath.sv]
`default_nettype none

module smm_datapath #(
  parameter int MAX_FRAME = 512
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire smm_pkg::smm_cmd_t             cmd_i,
  output smm_pkg::smm_sts_t                  sts_o,
  input  wire logic [smm_pkg::GAIN_W-1:0]    gain_i,
  input  wire logic [smm_pkg::SMP_W-1:0]     clip_i,
  input  wire logic [smm_pkg::IN_W-1:0]      in_data_i,
  input  wire logic                          in_last_i,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [smm_pkg::OUT_W-1:0]          out_tdata,
  output logic                               out_tlast
);

  localparam int CNT_W  = $clog2(MAX_FRAME + 1);
  localparam int SUM_W  = CNT_W + smm_pkg::SMP_W;
  localparam int STAT_W = smm_pkg::OUT_W - smm_pkg::SMP_W;
  localparam logic signed [smm_pkg::PROD_W-1:0] PROD_HI = smm_pkg::PROD_W'(smm_pkg::SMP_MAX);
  localparam logic signed [smm_pkg::PROD_W-1:0] PROD_LO = smm_pkg::PROD_W'(smm_pkg::SMP_MIN);

  // Input capture and shared gain multiplier
  logic signed [smm_pkg::SMP_W-1:0]  left_raw_r;
  logic                              last_r;
  logic signed [smm_pkg::SMP_W-1:0]  gr_r, gl_r;
  logic signed [smm_pkg::SMP_W-1:0]  mul_a;
  logic signed [smm_pkg::PROD_W-1:0] prod;
  logic signed [smm_pkg::SMP_W-1:0]  sat;

  assign mul_a = cmd_i.take_in ? $signed(in_data_i[smm_pkg::SMP_W-1:0]) : left_raw_r;
  assign prod  = mul_a * $signed({1'b0, gain_i});

  always_comb begin
    if (prod > PROD_HI) begin
      sat = smm_pkg::SMP_MAX;
    end else if (prod < PROD_LO) begin
      sat = smm_pkg::SMP_MIN;
    end else begin
      sat = prod[smm_pkg::SMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.take_in) begin
      left_raw_r <= $signed(in_data_i[2*smm_pkg::SMP_W-1:smm_pkg::SMP_W]);
      last_r     <= in_last_i;
      gr_r       <= sat;
    end
    if (cmd_i.mul_left) begin
      gl_r <= sat;
    end
  end

  // Frame statistics
  logic [SUM_W-1:0]                 sum_l_r, sum_r_r;
  logic [smm_pkg::SMP_W-1:0]        peak_l_r, peak_r_r;
  logic signed [smm_pkg::SMP_W-1:0] min_l_r, max_l_r, min_r_r, max_r_r;
  logic [CNT_W-1:0]                 eq_cnt_r, clip_l_cnt_r, clip_r_cnt_r, pair_cnt_r;
  logic [smm_pkg::TOTAL_W-1:0]      total_r;
  logic                             end_r;
  logic signed [smm_pkg::SMP_W-1:0] mono_r;

  logic [smm_pkg::SMP_W-1:0]        abs_l, abs_r;
  logic signed [smm_pkg::SMP_W:0]   pair_sum, pair_adj;
  logic [CNT_W-1:0]                 pair_cnt_inc;
  logic                             frame_end;
  logic                             clear;

  assign abs_l        = gl_r[smm_pkg::SMP_W-1] ? (~gl_r + 1'b1) : gl_r;
  assign abs_r        = gr_r[smm_pkg::SMP_W-1] ? (~gr_r + 1'b1) : gr_r;
  assign pair_sum     = {gl_r[smm_pkg::SMP_W-1], gl_r} + {gr_r[smm_pkg::SMP_W-1], gr_r};
  // round toward zero: bias negative sums by one before the shift
  assign pair_adj     = pair_sum + $signed({{smm_pkg::SMP_W{1'b0}}, pair_sum[smm_pkg::SMP_W]});
  assign pair_cnt_inc = pair_cnt_r + CNT_W'(1);
  assign frame_end    = last_r || (pair_cnt_r == CNT_W'(MAX_FRAME - 1));
  assign clear        = cmd_i.load_out && end_r;

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      sum_l_r      <= '0;
      sum_r_r      <= '0;
      peak_l_r     <= '0;
      peak_r_r     <= '0;
      min_l_r      <= smm_pkg::SMP_MAX;
      max_l_r      <= smm_pkg::SMP_MIN;
      min_r_r      <= smm_pkg::SMP_MAX;
      max_r_r      <= smm_pkg::SMP_MIN;
      eq_cnt_r     <= '0;
      clip_l_cnt_r <= '0;
      clip_r_cnt_r <= '0;
      pair_cnt_r   <= '0;
    end else if (cmd_i.accum) begin
      sum_l_r    <= sum_l_r + SUM_W'(abs_l);
      sum_r_r    <= sum_r_r + SUM_W'(abs_r);
      pair_cnt_r <= pair_cnt_inc;
      if (abs_l > peak_l_r) peak_l_r <= abs_l;
      if (abs_r > peak_r_r) peak_r_r <= abs_r;
      if (gl_r < min_l_r) min_l_r <= gl_r;
      if (gl_r > max_l_r) max_l_r <= gl_r;
      if (gr_r < min_r_r) min_r_r <= gr_r;
      if (gr_r > max_r_r) max_r_r <= gr_r;
      if (gl_r == gr_r) eq_cnt_r <= eq_cnt_r + CNT_W'(1);
      if (abs_l >= clip_i) clip_l_cnt_r <= clip_l_cnt_r + CNT_W'(1);
      if (abs_r >= clip_i) clip_r_cnt_r <= clip_r_cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      end_r   <= 1'b0;
    end else if (cmd_i.accum) begin
      end_r <= frame_end;
      if (frame_end) begin
        total_r <= total_r + smm_pkg::TOTAL_W'(pair_cnt_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.accum) begin
      mono_r <= pair_adj[smm_pkg::SMP_W:1];
    end
  end

  // End-of-frame divisions through one shared divider
  logic [SUM_W-1:0]          dividend;
  logic                      div_done;
  logic [smm_pkg::QUO_W-1:0] quo;
  logic [smm_pkg::QUO_W-1:0] mean_l_r, mean_r_r;
  logic [smm_pkg::PERM_W-1:0] eq_pm_r, clip_l_pm_r, clip_r_pm_r;

  always_comb begin
    case (cmd_i.div_sel)
      smm_pkg::DIV_MEAN_L: dividend = sum_l_r;
      smm_pkg::DIV_MEAN_R: dividend = sum_r_r;
      smm_pkg::DIV_EQUAL:  dividend = SUM_W'(eq_cnt_r) * SUM_W'(smm_pkg::PERMILLE);
      smm_pkg::DIV_CLIP_L: dividend = SUM_W'(clip_l_cnt_r) * SUM_W'(smm_pkg::PERMILLE);
      smm_pkg::DIV_CLIP_R: dividend = SUM_W'(clip_r_cnt_r) * SUM_W'(smm_pkg::PERMILLE);
      default:             dividend = '0;
    endcase
  end

  smm_div #(
    .DIVD_W (SUM_W),
    .DSR_W  (CNT_W)
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (pair_cnt_r),
    .done_o     (div_done),
    .quo_o      (quo)
  );

  always_ff @(posedge clk) begin
    if (cmd_i.div_store) begin
      case (cmd_i.div_sel)
        smm_pkg::DIV_MEAN_L: mean_l_r    <= quo;
        smm_pkg::DIV_MEAN_R: mean_r_r    <= quo;
        smm_pkg::DIV_EQUAL:  eq_pm_r     <= quo[smm_pkg::PERM_W-1:0];
        smm_pkg::DIV_CLIP_L: clip_l_pm_r <= quo[smm_pkg::PERM_W-1:0];
        smm_pkg::DIV_CLIP_R: clip_r_pm_r <= quo[smm_pkg::PERM_W-1:0];
        default: ;
      endcase
    end
  end

  // Output register
  logic [STAT_W-1:0]         stats;
  logic [smm_pkg::SMP_W-1:0] span_l, span_r;
  logic                      out_valid_r;
  logic [smm_pkg::OUT_W-1:0] out_data_r;
  logic                      out_last_r;

  assign span_l = max_l_r - min_l_r;
  assign span_r = max_r_r - min_r_r;
  assign stats  = end_r ? {2'b00, total_r, clip_r_pm_r, clip_l_pm_r, eq_pm_r, span_r, span_l,
                           peak_r_r, peak_l_r, mean_r_r, mean_l_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load_out) begin
      out_data_r <= {stats, mono_r};
      out_last_r <= end_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  assign sts_o.frame_end = frame_end;
  assign sts_o.div_done  = div_done;
  assign sts_o.out_free  = !out_valid_r || out_tready;

endmodule

`default_nettype wire

[rtl/core/smm_ctrl.sv]
`default_nettype none

module smm_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid_i,
  input  wire logic               muted_i,
  input  wire smm_pkg::smm_sts_t  sts_i,
  output logic                    in_tready_o,
  output smm_pkg::smm_cmd_t       cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MUL   = 6'b000010,
    ST_ACC   = 6'b000100,
    ST_DGO   = 6'b001000,
    ST_DWAIT = 6'b010000,
    ST_EMIT  = 6'b100000
  } ctrl_state_t;

  ctrl_state_t           state_r, state_nxt;
  smm_pkg::smm_div_sel_t sel_r, sel_nxt;

  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    cmd_o         = '0;
    cmd_o.div_sel = sel_r;
    unique case (state_r)
      ST_IDLE: begin
        // drop requests while muted
        if (in_tvalid_i && !muted_i) begin
          cmd_o.take_in = 1'b1;
          state_nxt     = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_left = 1'b1;
        state_nxt      = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.accum = 1'b1;
        if (sts_i.frame_end) begin
          sel_nxt   = smm_pkg::DIV_MEAN_L;
          state_nxt = ST_DGO;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_DGO: begin
        cmd_o.div_start = 1'b1;
        state_nxt       = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (sts_i.div_done) begin
          cmd_o.div_store = 1'b1;
          if (sel_r == smm_pkg::DIV_CLIP_R) begin
            state_nxt = ST_EMIT;
          end else begin
            sel_nxt   = smm_pkg::smm_div_sel_t'(sel_r + 3'd1);
            state_nxt = ST_DGO;
          end
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sel_r   <= smm_pkg::DIV_MEAN_L;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

  assign in_tready_o = (state_r == ST_IDLE);

endmodule

`default_nettype wire
